// ===== rtl/core/allocation_statistics_monitor_assert.svh =====
// Assertion macros for the allocation statistics monitor.
`ifndef ALLOCATION_STATISTICS_MONITOR_ASSERT_SVH
`define ALLOCATION_STATISTICS_MONITOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASM_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASM_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASM_ASSERT(label, clk, rstn, prop, msg)
`define ASM_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/asm_pkg.sv =====
// ----------------------------------------------------------------------------
// asm_pkg
// Shared types and constants of the allocation statistics monitor.
// ----------------------------------------------------------------------------
package asm_pkg;
    localparam int SIZE_BITS  = 48;
    localparam int EPOCH_BITS = 32;
    localparam int NUM_HIST   = 7;
    localparam int HIST_BITS  = 3;

    typedef enum logic [3:0] {
        CMD_ALLOC = 4'd0, CMD_FREE = 4'd1, CMD_GALLOC = 4'd2, CMD_GFREE = 4'd3,
        CMD_MMAP = 4'd4, CMD_MUNMAP = 4'd5, CMD_LFREE = 4'd6, CMD_REALLOC = 4'd7,
        CMD_READ = 4'd8
    } cmd_t;

    localparam logic [HIST_BITS-1:0] H_ALLOC  = 3'd0;
    localparam logic [HIST_BITS-1:0] H_FREE   = 3'd1;
    localparam logic [HIST_BITS-1:0] H_GALLOC = 3'd2;
    localparam logic [HIST_BITS-1:0] H_GFREE  = 3'd3;
    localparam logic [HIST_BITS-1:0] H_MMAP   = 3'd4;
    localparam logic [HIST_BITS-1:0] H_MUNMAP = 3'd5;
    localparam logic [HIST_BITS-1:0] H_LIFE   = 3'd6;

    localparam logic [5:0] IDX_ZERO  = 6'd35;
    localparam logic [5:0] IDX_RCNT  = 6'd36;
    localparam logic [5:0] IDX_DELTA = 6'd37;
    localparam logic [5:0] IDX_EPOCH = 6'd38;

    // Decoded item handed from the front end to the back end.
    typedef struct packed {
        logic                  is_alloc;   // live bytes grow, high-water update
        logic                  is_free;    // free path
        logic                  is_lfree;
        logic                  is_realloc;
        logic                  is_read;
        logic                  pre_valid;  // extra history first (mmap/munmap)
        logic [HIST_BITS-1:0]  pre_hist;
        logic                  pre_nocount;
        logic [HIST_BITS-1:0]  main_hist;
        logic                  zero_size;
        logic [63:0]           size;
        logic [63:0]           delta;
        logic [63:0]           age;
        logic [EPOCH_BITS-1:0] epoch;
        logic [HIST_BITS-1:0]  rd_hist;
        logic [2:0]            rd_qty;
        logic [5:0]            rd_idx;
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PRE, ST_MAIN, ST_DIV, ST_OUT
    } be_state_t;
endpackage

// ===== rtl/core/allocation_statistics_monitor.sv =====
// ----------------------------------------------------------------------------
// allocation_statistics_monitor
// Running count, min, max and sum statistics over allocation trace items.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Payload
// s_       in   s_valid/s_ready    cmd, size, old size, epoch, partial, age, index
// m_       out  m_valid/m_ready    read data, live, high water, peak, underflow
//
// In the back end an item runs through ST_MAIN and ST_OUT (mmap and munmap go
// through ST_PRE first, to update an extra history); a mean read also waits
// in ST_DIV for the bit-serial divider. The front end queues up to two decoded
// items, so input keeps flowing while a result waits in the output register.
// Reset is synchronous, active low, and clears every statistic at once.
`include "allocation_statistics_monitor_assert.svh"
module allocation_statistics_monitor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_cmd,
    input  logic [47:0] s_size_value,
    input  logic [47:0] s_old_size,
    input  logic [31:0] s_peak_epoch,
    input  logic        s_partial_unmap,
    input  logic [63:0] s_chunk_age_ticks,
    input  logic [5:0]  s_stat_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_read_data,
    output logic [63:0] m_live_now,
    output logic [63:0] m_live_high_water,
    output logic [63:0] m_peak_live,
    output logic        m_underflow_flag
);
    import asm_pkg::*;

    logic q_valid, q_ready;
    op_t  q_op;

    // Front end: decode and queue.
    asm_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_cmd(s_cmd), .s_size_value(s_size_value), .s_old_size(s_old_size),
        .s_peak_epoch(s_peak_epoch), .s_partial_unmap(s_partial_unmap),
        .s_chunk_age_ticks(s_chunk_age_ticks), .s_stat_index(s_stat_index),
        .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op)
    );

    // Back end: state updates, reads and result register.
    asm_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_op(q_op), .m_valid(m_valid), .m_ready(m_ready),
        .m_read_data(m_read_data), .m_live_now(m_live_now),
        .m_live_high_water(m_live_high_water), .m_peak_live(m_peak_live),
        .m_underflow_flag(m_underflow_flag)
    );

    // The high-water mark never falls below the live byte count.
    `ASM_ASSERT(a_hw_ge_live, aclk, aresetn, m_valid |-> m_live_high_water >= m_live_now, "high water below live")
    // A result that is not taken holds its value.
    `ASM_ASSERT(a_hold, aclk, aresetn, m_valid && !m_ready |=> $stable(m_read_data), "result changed while stalled")
    // An underflow always leaves live bytes at zero.
    `ASM_ASSERT(a_uflow, aclk, aresetn, m_valid && m_underflow_flag |-> m_live_now == 64'd0, "underflow with live bytes")
endmodule

// ===== rtl/core/asm_front.sv =====
// ----------------------------------------------------------------------------
// asm_front
// Accepts trace items, decodes them and pushes them into a two-entry queue.
// ----------------------------------------------------------------------------
module asm_front (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_cmd,
    input  logic [47:0] s_size_value,
    input  logic [47:0] s_old_size,
    input  logic [31:0] s_peak_epoch,
    input  logic        s_partial_unmap,
    input  logic [63:0] s_chunk_age_ticks,
    input  logic [5:0]  s_stat_index,
    output logic        q_valid,
    input  logic        q_ready,
    output asm_pkg::op_t q_op
);
    import asm_pkg::*;

    op_t         dec;
    op_t         q_mem_reg [2];
    logic        wptr_reg, rptr_reg;
    logic [1:0]  cnt_reg;
    logic [SIZE_BITS-1:0] sz, osz;
    logic [5:0]  idx;
    logic [3:0]  h5;

    assign sz  = s_size_value[SIZE_BITS-1:0];
    assign osz = s_old_size[SIZE_BITS-1:0];
    assign idx = s_stat_index;

    always_comb begin
        h5 = 4'd0;
        for (int i = 1; i < 8; i++) begin
            if (idx >= 6'(i * 5)) h5 = 4'(i);
        end
    end

    always_comb begin
        dec = '0;
        dec.size = 64'(sz);
        dec.age = s_chunk_age_ticks;
        dec.epoch = s_peak_epoch[EPOCH_BITS-1:0];
        dec.zero_size = (sz == '0);
        dec.delta = (osz > sz) ? 64'(osz - sz) : 64'(sz - osz);
        dec.rd_idx = idx;
        dec.rd_hist = h5[HIST_BITS-1:0];
        dec.rd_qty = 3'(idx - 6'(h5) * 6'd5);
        dec.pre_nocount = s_partial_unmap;
        case (s_cmd)
            CMD_ALLOC:   begin dec.is_alloc = 1'b1; dec.main_hist = H_ALLOC; end
            CMD_FREE:    begin dec.is_free = 1'b1; dec.main_hist = H_FREE; end
            CMD_GALLOC:  begin dec.is_alloc = 1'b1; dec.main_hist = H_GALLOC; end
            CMD_GFREE:   begin dec.is_free = 1'b1; dec.main_hist = H_GFREE; end
            CMD_MMAP: begin
                dec.is_alloc = 1'b1; dec.main_hist = H_ALLOC;
                dec.pre_valid = 1'b1; dec.pre_hist = H_MMAP; dec.pre_nocount = 1'b0;
            end
            CMD_MUNMAP: begin
                dec.is_free = 1'b1; dec.main_hist = H_FREE;
                dec.pre_valid = 1'b1; dec.pre_hist = H_MUNMAP;
            end
            CMD_LFREE:   begin dec.is_lfree = 1'b1; dec.main_hist = H_LIFE; end
            CMD_REALLOC: dec.is_realloc = 1'b1;
            CMD_READ:    dec.is_read = 1'b1;
            default:     ;
        endcase
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_op    = q_mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) q_mem_reg[wptr_reg] <= dec;
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (s_valid && s_ready) wptr_reg <= ~wptr_reg;
            if (q_valid && q_ready) rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + 2'(s_valid && s_ready) - 2'(q_valid && q_ready);
        end
    end
endmodule

// ===== rtl/core/asm_div.sv =====
// ----------------------------------------------------------------------------
// asm_div
// Radix-2 restoring divider, 64 by 64 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module asm_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    logic [63:0] quo_reg, rem_reg, dvs_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic [64:0] trial;

    assign trial    = {rem_reg, quo_reg[63]} - {1'b0, dvs_reg};
    assign quotient = quo_reg;
    assign done     = busy_reg && (cnt_reg == 7'd0);

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg && cnt_reg != 7'd0) begin
            if (!trial[64]) rem_reg <= trial[63:0];
            else rem_reg <= {rem_reg[62:0], quo_reg[63]};
            quo_reg <= {quo_reg[62:0], ~trial[64]};
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 7'd64;
        end else if (busy_reg) begin
            if (cnt_reg == 7'd0) busy_reg <= 1'b0;
            else cnt_reg <= cnt_reg - 7'd1;
        end
    end
endmodule

// ===== rtl/core/asm_back.sv =====
// ----------------------------------------------------------------------------
// asm_back
// Executes decoded items against the statistics state and drives results.
// ----------------------------------------------------------------------------
module asm_back (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         q_valid,
    output logic         q_ready,
    input  asm_pkg::op_t q_op,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [63:0]  m_read_data,
    output logic [63:0]  m_live_now,
    output logic [63:0]  m_live_high_water,
    output logic [63:0]  m_peak_live,
    output logic         m_underflow_flag
);
    import asm_pkg::*;

    logic [63:0] cnt_reg [NUM_HIST];
    logic [63:0] min_reg [NUM_HIST];
    logic [63:0] max_reg [NUM_HIST];
    logic [63:0] sum_reg [NUM_HIST];
    logic [63:0] zero_reg, live_reg, lmax_reg, snap_reg, rcnt_reg, rdelta_reg;
    logic [EPOCH_BITS-1:0] epoch_reg;

    be_state_t state_reg, state_next;
    op_t   op_reg;
    logic  out_valid_reg;
    logic [63:0] rdata_reg;
    logic  uflow_reg;

    // Result register: holds the item on the output while the next one runs.
    logic [63:0] out_rdata_reg, out_live_reg, out_lmax_reg, out_snap_reg;
    logic        out_uflow_reg;

    logic        do_hist, nocount;
    logic [HIST_BITS-1:0] h;
    logic [63:0] v, rd_sel, live_next;
    logic        div_start, div_done;
    logic [63:0] div_q;

    asm_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(sum_reg[op_reg.rd_hist]), .divisor(cnt_reg[op_reg.rd_hist]),
        .done(div_done), .quotient(div_q)
    );

    assign q_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_read_data = out_rdata_reg;
    assign m_live_now = out_live_reg;
    assign m_live_high_water = out_lmax_reg;
    assign m_peak_live = out_snap_reg;
    assign m_underflow_flag = out_uflow_reg;

    always_comb begin
        rd_sel = '0;
        if (op_reg.rd_idx < 6'd35) begin
            case (op_reg.rd_qty)
                3'd0: rd_sel = cnt_reg[op_reg.rd_hist];
                3'd1: rd_sel = min_reg[op_reg.rd_hist];
                3'd2: rd_sel = max_reg[op_reg.rd_hist];
                3'd3: rd_sel = sum_reg[op_reg.rd_hist];
                default: rd_sel = '0;
            endcase
        end else begin
            case (op_reg.rd_idx)
                IDX_ZERO:  rd_sel = zero_reg;
                IDX_RCNT:  rd_sel = rcnt_reg;
                IDX_DELTA: rd_sel = rdelta_reg;
                IDX_EPOCH: rd_sel = 64'(epoch_reg);
                default:   rd_sel = '0;
            endcase
        end
    end

    // History update selection for the current step.
    always_comb begin
        do_hist = 1'b0;
        nocount = 1'b0;
        h = op_reg.main_hist;
        v = op_reg.size;
        if (state_reg == ST_PRE) begin
            do_hist = 1'b1;
            h = op_reg.pre_hist;
            nocount = op_reg.pre_nocount;
        end else if (state_reg == ST_MAIN) begin
            if (op_reg.is_lfree) begin
                do_hist = (op_reg.age != '0);
                v = op_reg.age;
            end else begin
                do_hist = (op_reg.is_alloc || op_reg.is_free) && !op_reg.zero_size;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE: if (q_valid) state_next = q_op.pre_valid ? ST_PRE : ST_MAIN;
            ST_PRE:  state_next = ST_MAIN;
            ST_MAIN: begin
                if (op_reg.is_read && op_reg.rd_idx < 6'd35 && op_reg.rd_qty == 3'd4 &&
                    cnt_reg[op_reg.rd_hist] != '0) begin
                    div_start = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV:  if (div_done) state_next = ST_OUT;
            ST_OUT:  if (!out_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign live_next = op_reg.is_lfree ?
        ((op_reg.size > live_reg) ? 64'd0 : live_reg - op_reg.size) :
        live_reg + op_reg.size;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && q_valid) op_reg <= q_op;
        if (state_reg == ST_MAIN) begin
            rdata_reg <= op_reg.is_read ? rd_sel : 64'd0;
            uflow_reg <= op_reg.is_lfree && (op_reg.size > live_reg);
        end
        if (state_reg == ST_DIV && div_done) rdata_reg <= div_q;
        if (state_reg == ST_OUT && (!out_valid_reg || m_ready)) begin
            out_rdata_reg <= rdata_reg;
            out_live_reg  <= live_reg;
            out_lmax_reg  <= lmax_reg;
            out_snap_reg  <= snap_reg;
            out_uflow_reg <= uflow_reg;
        end
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_HIST; i++) begin
                cnt_reg[i] <= '0; min_reg[i] <= '0; max_reg[i] <= '0; sum_reg[i] <= '0;
            end
            zero_reg <= '0; live_reg <= '0; lmax_reg <= '0; snap_reg <= '0;
            rcnt_reg <= '0; rdelta_reg <= '0; epoch_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (m_valid && m_ready) out_valid_reg <= 1'b0;
            if (state_reg == ST_OUT && (!out_valid_reg || m_ready)) out_valid_reg <= 1'b1;
            if (do_hist) begin
                if (cnt_reg[h] == '0 || v < min_reg[h]) min_reg[h] <= v;
                if (cnt_reg[h] == '0 || v > max_reg[h]) max_reg[h] <= v;
                if (!nocount) cnt_reg[h] <= cnt_reg[h] + 64'd1;
                sum_reg[h] <= sum_reg[h] + v;
            end
            if (state_reg == ST_MAIN) begin
                if ((op_reg.is_alloc || op_reg.is_free) && op_reg.zero_size)
                    zero_reg <= zero_reg + 64'd1;
                if ((op_reg.is_alloc || op_reg.is_lfree ||
                     (op_reg.is_free && !op_reg.zero_size)) && epoch_reg < op_reg.epoch) begin
                    epoch_reg <= op_reg.epoch;
                    snap_reg <= live_reg;
                end
                if (op_reg.is_alloc || op_reg.is_lfree) live_reg <= live_next;
                if (op_reg.is_alloc && live_next > lmax_reg) lmax_reg <= live_next;
                if (op_reg.is_realloc) begin
                    rcnt_reg <= rcnt_reg + 64'd1;
                    rdelta_reg <= rdelta_reg + op_reg.delta;
                end
            end
        end
    end
endmodule

// ===== bench/allocation_statistics_monitor_tb.sv =====
// ----------------------------------------------------------------------------
// allocation_statistics_monitor_tb
// Self-checking bench for the allocation statistics monitor: directed and
// random trace items are sent, each result is predicted and compared field by
// field as it leaves the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module allocation_statistics_monitor_tb;
    import asm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 380;

    // One trace item as it is offered on the input channel.
    typedef struct {
        logic [3:0]  cmd;
        logic [47:0] size;
        logic [47:0] old;
        logic [31:0] epoch;
        logic        partial;
        logic [63:0] age;
        logic [5:0]  idx;
    } trace_item_t;

    // One result as it is expected on the output channel.
    typedef struct {
        logic [63:0] rdata;
        logic [63:0] live;
        logic [63:0] high_water;
        logic [63:0] peak;
        logic        uflow;
    } stats_result_t;

    // The scoreboard holds its own copy of every statistic and a queue of
    // the results that are still owed by the block.
    class stats_scoreboard;
        logic [63:0] cnt[NUM_HIST];
        logic [63:0] mn[NUM_HIST];
        logic [63:0] mx[NUM_HIST];
        logic [63:0] sm[NUM_HIST];
        logic [63:0] zero_events, live, live_max, peak, resizes, delta_total;
        logic [31:0] epoch_seen;
        stats_result_t pending[$];
        int errors;
        int checked;

        function void clear();
            for (int h = 0; h < NUM_HIST; h++) begin
                cnt[h] = '0; mn[h] = '0; mx[h] = '0; sm[h] = '0;
            end
            zero_events = '0; live = '0; live_max = '0; peak = '0;
            resizes = '0; delta_total = '0; epoch_seen = '0;
            errors = 0; checked = 0;
        endfunction

        function void hist_add(int h, logic [63:0] v);
            if (cnt[h] == 0) begin
                mn[h] = v;
                mx[h] = v;
            end else begin
                if (v < mn[h]) mn[h] = v;
                if (v > mx[h]) mx[h] = v;
            end
            cnt[h] = cnt[h] + 1;
            sm[h]  = sm[h] + v;
        endfunction

        function void bump_peak(logic [31:0] e);
            if (epoch_seen < e) begin
                epoch_seen = e;
                peak = live;
            end
        endfunction

        function void grow(int h, logic [63:0] v, logic [31:0] e);
            if (v == 0) zero_events = zero_events + 1;
            else hist_add(h, v);
            bump_peak(e);
            live = live + v;
            if (live > live_max) live_max = live;
        endfunction

        function void shrink(int h, logic [63:0] v, logic [31:0] e);
            if (v == 0) begin
                zero_events = zero_events + 1;
            end else begin
                bump_peak(e);
                hist_add(h, v);
            end
        endfunction

        function logic [63:0] lookup(logic [5:0] idx);
            int h;
            h = idx / 5;
            if (idx < 35) begin
                case (idx % 5)
                    0: return cnt[h];
                    1: return mn[h];
                    2: return mx[h];
                    3: return sm[h];
                    default: return (cnt[h] == 0) ? 64'd0 : sm[h] / cnt[h];
                endcase
            end
            if (idx == IDX_ZERO)  return zero_events;
            if (idx == IDX_RCNT)  return resizes;
            if (idx == IDX_DELTA) return delta_total;
            if (idx == IDX_EPOCH) return {32'd0, epoch_seen};
            return 64'd0;
        endfunction

        // An item has been taken by the block: update the statistics and
        // queue the result it must produce.
        function void note_item(trace_item_t it);
            stats_result_t r;
            logic [63:0] sz, od;
            sz = {16'd0, it.size};
            od = {16'd0, it.old};
            r.rdata = '0;
            r.uflow = 1'b0;
            case (it.cmd)
                CMD_ALLOC:  grow(H_ALLOC, sz, it.epoch);
                CMD_FREE:   shrink(H_FREE, sz, it.epoch);
                CMD_GALLOC: grow(H_GALLOC, sz, it.epoch);
                CMD_GFREE:  shrink(H_GFREE, sz, it.epoch);
                CMD_MMAP: begin
                    hist_add(H_MMAP, sz);
                    grow(H_ALLOC, sz, it.epoch);
                end
                CMD_MUNMAP: begin
                    hist_add(H_MUNMAP, sz);
                    if (it.partial) cnt[H_MUNMAP] = cnt[H_MUNMAP] - 1;
                    shrink(H_FREE, sz, it.epoch);
                end
                CMD_LFREE: begin
                    bump_peak(it.epoch);
                    if (sz > live) begin
                        live = '0;
                        r.uflow = 1'b1;
                    end else begin
                        live = live - sz;
                    end
                    if (it.age != 0) hist_add(H_LIFE, it.age);
                end
                CMD_REALLOC: begin
                    resizes = resizes + 1;
                    delta_total = delta_total + ((od > sz) ? od - sz : sz - od);
                end
                CMD_READ: r.rdata = lookup(it.idx);
                default: ;
            endcase
            r.live = live;
            r.high_water = live_max;
            r.peak = peak;
            pending.push_back(r);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("MISMATCH result %0d %s: got %h expected %h", checked, what, got, want);
            errors++;
        endtask

        task check_result(stats_result_t got);
            stats_result_t want;
            if (pending.size() == 0) begin
                $display("MISMATCH result %0d arrived with nothing outstanding", checked);
                errors++;
            end else begin
                want = pending.pop_front();
                if (got.rdata !== want.rdata) report("read_data", got.rdata, want.rdata);
                if (got.live !== want.live) report("live_now", got.live, want.live);
                if (got.high_water !== want.high_water)
                    report("live_high_water", got.high_water, want.high_water);
                if (got.peak !== want.peak) report("peak_live", got.peak, want.peak);
                if (got.uflow !== want.uflow) report("underflow_flag", got.uflow, want.uflow);
            end
            checked++;
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [3:0]  s_cmd;
    logic [47:0] s_size_value;
    logic [47:0] s_old_size;
    logic [31:0] s_peak_epoch;
    logic        s_partial_unmap;
    logic [63:0] s_chunk_age_ticks;
    logic [5:0]  s_stat_index;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_read_data;
    logic [63:0] m_live_now;
    logic [63:0] m_live_high_water;
    logic [63:0] m_peak_live;
    logic        m_underflow_flag;

    stats_scoreboard sb;
    int          items_sent;
    int          idle_cycles;
    logic [31:0] epoch_base;

    always #10 aclk = ~aclk;

    allocation_statistics_monitor u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_size_value      (s_size_value),
        .s_old_size        (s_old_size),
        .s_peak_epoch      (s_peak_epoch),
        .s_partial_unmap   (s_partial_unmap),
        .s_chunk_age_ticks (s_chunk_age_ticks),
        .s_stat_index      (s_stat_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_read_data       (m_read_data),
        .m_live_now        (m_live_now),
        .m_live_high_water (m_live_high_water),
        .m_peak_live       (m_peak_live),
        .m_underflow_flag  (m_underflow_flag)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sizes are mostly modest so that live bytes move both ways; some are
    // zero and some span all 48 bits.
    function automatic logic [47:0] pick_size();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return 48'({$urandom, $urandom});
        return 48'($urandom_range(1, 5000));
    endfunction

    function automatic trace_item_t make_item(logic [3:0] cmd, logic [47:0] size,
                                              logic [47:0] old, logic [31:0] epoch,
                                              logic partial, logic [63:0] age,
                                              logic [5:0] idx);
        trace_item_t it;
        it.cmd = cmd; it.size = size; it.old = old; it.epoch = epoch;
        it.partial = partial; it.age = age; it.idx = idx;
        return it;
    endfunction

    // Random item with the epoch creeping upwards so that peaks keep coming.
    function automatic trace_item_t random_item();
        trace_item_t it;
        int r;
        r = $urandom_range(0, 99);
        if (r < 16)      it.cmd = CMD_ALLOC;
        else if (r < 26) it.cmd = CMD_FREE;
        else if (r < 34) it.cmd = CMD_GALLOC;
        else if (r < 40) it.cmd = CMD_GFREE;
        else if (r < 47) it.cmd = CMD_MMAP;
        else if (r < 54) it.cmd = CMD_MUNMAP;
        else if (r < 66) it.cmd = CMD_LFREE;
        else if (r < 73) it.cmd = CMD_REALLOC;
        else if (r < 96) it.cmd = CMD_READ;
        else             it.cmd = 4'($urandom_range(9, 15));
        it.size    = pick_size();
        it.old     = pick_size();
        epoch_base = epoch_base + $urandom_range(0, 2);
        it.epoch   = ($urandom_range(0, 3) == 0) ? epoch_base - $urandom_range(0, 5)
                                                 : epoch_base;
        it.partial = 1'($urandom_range(0, 1));
        it.age     = ($urandom_range(0, 4) == 0) ? 64'd0 : {$urandom, $urandom};
        // Reads span the whole index field, unknown indexes included.
        it.idx     = 6'($urandom_range(0, 63));
        return it;
    endfunction

    // Offer one item and hold it until the block takes it. Valid is first
    // dropped for a random gap, if the gap picked is not zero.
    task send_item(trace_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_cmd             <= it.cmd;
        s_size_value      <= it.size;
        s_old_size        <= it.old;
        s_peak_epoch      <= it.epoch;
        s_partial_unmap   <= it.partial;
        s_chunk_age_ticks <= it.age;
        s_stat_index      <= it.idx;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
        items_sent++;
    endtask

    initial begin
        trace_item_t it;
        sb = new();
        sb.clear();
        items_sent = 0;
        epoch_base = 32'd10;
        aresetn           <= 1'b0;
        s_valid           <= 1'b0;
        s_cmd             <= '0;
        s_size_value      <= '0;
        s_old_size        <= '0;
        s_peak_epoch      <= '0;
        s_partial_unmap   <= 1'b0;
        s_chunk_age_ticks <= '0;
        s_stat_index      <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: empty means, zero sizes, a partial unmap on an empty
        // history, clamped linked frees, both realloc directions, unknown
        // commands and indexes, and the widest field values.
        send_item(make_item(CMD_READ, '0, '0, '0, 1'b0, '0, 6'd4));
        send_item(make_item(CMD_READ, '0, '0, '0, 1'b0, '0, 6'd34));
        send_item(make_item(CMD_ALLOC, '0, '0, 32'd1, 1'b0, '0, '0));
        send_item(make_item(CMD_FREE, '0, '0, 32'd2, 1'b0, '0, '0));
        send_item(make_item(CMD_MUNMAP, 48'd300, '0, 32'd2, 1'b1, '0, '0));
        send_item(make_item(CMD_ALLOC, '1, '0, 32'd3, 1'b0, '0, '0));
        send_item(make_item(CMD_GALLOC, 48'd1, '0, 32'd4, 1'b0, '0, '0));
        send_item(make_item(CMD_FREE, 48'd64, '0, 32'd5, 1'b0, '0, '0));
        send_item(make_item(CMD_GFREE, '1, '0, 32'd5, 1'b0, '0, '0));
        send_item(make_item(CMD_MMAP, '0, '0, 32'd6, 1'b0, '0, '0));
        send_item(make_item(CMD_MMAP, 48'd4096, '0, 32'd7, 1'b0, '0, '0));
        send_item(make_item(CMD_MUNMAP, 48'd4096, '0, 32'd7, 1'b0, '0, '0));
        send_item(make_item(CMD_MUNMAP, 48'd8, '1, 32'd8, 1'b1, '0, '0));
        send_item(make_item(CMD_LFREE, 48'd100, '0, 32'd9, 1'b0, '1, '0));
        send_item(make_item(CMD_LFREE, '1, '0, 32'd9, 1'b0, '0, '0));
        send_item(make_item(CMD_LFREE, 48'd5, '0, 32'd9, 1'b0, 64'd1, '0));
        send_item(make_item(CMD_REALLOC, 48'd10, '1, '0, 1'b0, '0, '0));
        send_item(make_item(CMD_REALLOC, '1, 48'd3, '0, 1'b0, '0, '0));
        send_item(make_item(CMD_READ, '0, '0, '0, 1'b0, '0, 6'd29));
        send_item(make_item(CMD_READ, '0, '0, '0, 1'b0, '0, IDX_DELTA));
        send_item(make_item(CMD_READ, '0, '0, '0, 1'b0, '0, IDX_EPOCH));
        send_item(make_item(CMD_READ, '1, '1, '1, 1'b1, '1, 6'd39));
        send_item(make_item(4'd15, '1, '1, '1, 1'b1, '1, '1));
        send_item(make_item(4'd9, '0, '0, '0, 1'b0, '0, IDX_ZERO));

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            send_item(random_item());
        end

        // Tail: epochs over the full range, the largest last, then reads of
        // every statistic.
        for (int i = 0; i < 8; i++) begin
            it = random_item();
            it.epoch = $urandom;
            send_item(it);
        end
        send_item(make_item(CMD_ALLOC, 48'd7, '0, '1, 1'b0, '0, '0));
        for (int i = 0; i <= 38; i++) begin
            send_item(make_item(CMD_READ, '0, '0, '0, 1'b0, '0, i[5:0]));
        end

        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (sb.pending.size() != 0) begin
            $display("MISMATCH %0d results never arrived", sb.pending.size());
            sb.errors++;
        end
        $display("Run covered %0d items of every command, %0d results checked,",
                 items_sent, sb.checked);
        $display("with random gaps on both sides and one long output stall.");
        if (sb.errors == 0) begin
            $display("allocation_statistics_monitor_tb: clean");
        end else begin
            $display("allocation_statistics_monitor_tb: errors");
        end
        $finish;
    end

    // Receiver: random back-pressure, plus one long hold-off once traffic is
    // under way so that the block fills its queue and stops taking items.
    initial begin
        int stall;
        int held_off;
        stall = 0;
        held_off = 0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                stats_result_t got;
                got.rdata      = m_read_data;
                got.live       = m_live_now;
                got.high_water = m_live_high_water;
                got.peak       = m_peak_live;
                got.uflow      = m_underflow_flag;
                sb.check_result(got);
            end
            if (!held_off && sb.checked == 60) begin
                held_off = 1;
                stall = 400;
            end else if (stall == 0 && !(sb.checked > 150 && sb.checked < 200)) begin
                // Random back-pressure, except for a stretch of results (checked 151 to 199) with none at all.
                stall = pick_gap();
            end
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any handshake on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles", idle_cycles);
            $display("allocation_statistics_monitor_tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end
endmodule
